// File: rtl/fifo_replace_match_cache_defines.svh
// assertion macros used by the top-level rtl file
// expects clk and arst_n in the scope of use
`ifndef FIFO_REPLACE_MATCH_CACHE_DEFINES_SVH
`define FIFO_REPLACE_MATCH_CACHE_DEFINES_SVH

// same-cycle implication
`define FMC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fmc assertion failed");

// next-cycle implication
`define FMC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fmc assertion failed");

`endif

// File: rtl/fmc_pkg.sv
package fmc_pkg;

	typedef enum logic [1:0] {
		ACT_INSERT          = 2'd0,
		ACT_FIND_EXACT      = 2'd1,
		ACT_FIND_XY_RANGE   = 2'd2,
		ACT_FIND_CODE_RANGE = 2'd3
	} fmc_act_t;

	localparam logic [7:0] HOPS_UNKNOWN = 8'hff;

	// search request walking down the cell row, with the result it picks up
	typedef struct packed {
		logic       valid;
		logic       found;
		fmc_act_t   action;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] code;
		logic [7:0] frag;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [3:0] slot;
		logic [7:0] rx;
		logic [7:0] ry;
		logic [7:0] rfrag;
		logic [7:0] rhops;
	} fmc_tok_t;

	// entry data broadcast to the cells on insert
	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] code;
		logic [7:0] frag;
		logic [7:0] hops;
	} fmc_wr_t;

endpackage

// File: rtl/fmc_cell.sv
module fmc_cell
	import fmc_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     filled,
	input  logic     wr_en,
	input  fmc_wr_t  wr,
	input  fmc_tok_t tok_i,
	output fmc_tok_t tok_o
);

	localparam logic [3:0] SLOT = 4'(IDX);

	logic [7:0] x_q;
	logic [7:0] y_q;
	logic [7:0] code_q;
	logic [7:0] frag_q;
	logic [7:0] hops_q;
	logic       in_range;
	logic       xyc;
	logic       match;
	logic       take;
	fmc_tok_t   tok_d;
	fmc_tok_t   tok_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_q    <= wr.x;
			y_q    <= wr.y;
			code_q <= wr.code;
			frag_q <= wr.frag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hops_q <= HOPS_UNKNOWN;
		end else if (wr_en) begin
			hops_q <= wr.hops;
		end
	end

	always_comb begin
		in_range = (frag_q >= tok_i.lo) && (frag_q <= tok_i.hi);
		xyc      = (x_q == tok_i.x) && (y_q == tok_i.y) && (code_q == tok_i.code);
		unique case (tok_i.action)
			ACT_FIND_EXACT:      match = xyc && (frag_q == tok_i.frag);
			ACT_FIND_XY_RANGE:   match = xyc && in_range;
			ACT_FIND_CODE_RANGE: match = (code_q == tok_i.code) && in_range;
			default:             match = 1'b0;
		endcase
		take  = tok_i.valid && !tok_i.found && filled && match;
		tok_d = tok_i;
		if (take) begin
			tok_d.found = 1'b1;
			tok_d.slot  = SLOT;
			tok_d.rx    = x_q;
			tok_d.ry    = y_q;
			tok_d.rfrag = frag_q;
			tok_d.rhops = hops_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule

// File: rtl/fifo_replace_match_cache.sv
// channel   | handshake        | fields
// ----------+------------------+-------------------------------------------------
// request   | start, busy      | action, pos_x, pos_y, code_id, frag,
//           |                  | range_min, range_max, hops_in
// result    | done (strobe)    | hit, slot, match_x, match_y, match_frag, match_hops
//
// a request is taken at a rising edge with start high and busy low
// insert: result strobed in the cycle after the request, next request may follow at once
// lookup: the request is registered at the head of the chain, then walks the row of DEPTH
//   cells one cell per cycle; the result comes from the last cell, busy is high during the walk
// arst_n clears control state and sets every hop count to unknown
// done is a single-cycle strobe; the receiver cannot stall it
`include "fifo_replace_match_cache_defines.svh"

module fifo_replace_match_cache
	import fmc_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] action,
	input  logic [7:0] pos_x,
	input  logic [7:0] pos_y,
	input  logic [7:0] code_id,
	input  logic [7:0] frag,
	input  logic [7:0] range_min,
	input  logic [7:0] range_max,
	input  logic [7:0] hops_in,
	output logic       done,
	output logic       hit,
	output logic [3:0] slot,
	output logic [7:0] match_x,
	output logic [7:0] match_y,
	output logic [7:0] match_frag,
	output logic [7:0] match_hops
);

	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	// request handling
	fmc_act_t         act;
	logic             accept;
	logic             ins_acc;
	logic             look_acc;

	// ring bookkeeping
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  wp_next;
	logic [FILL_W-1:0] fill_q;
	logic              busy_q;

	// insert result register
	logic       ins_v_q;
	logic [3:0] ins_slot_q;
	logic [7:0] ins_x_q;
	logic [7:0] ins_y_q;
	logic [7:0] ins_frag_q;
	logic [7:0] ins_hops_q;

	// search chain: link[i] feeds cell i, link[DEPTH] is the finished search
	fmc_tok_t   req_q;
	fmc_tok_t   link [0:DEPTH];
	fmc_wr_t    wr;
	logic [DEPTH-1:0] filled;
	logic [DEPTH-1:0] wr_en;

	assign act      = fmc_act_t'(action);
	assign accept   = start && !busy_q;
	assign ins_acc  = accept && (act == ACT_INSERT);
	assign look_acc = accept && (act != ACT_INSERT);
	assign busy     = busy_q;

	// ring pointer wraps at DEPTH, not at a power of two
	assign wp_next = (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= PTR_W'(DEPTH - 1);
			fill_q <= '0;
		end else if (ins_acc) begin
			wp_q <= wp_next;
			if (fill_q < FILL_W'(DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// busy covers the walk; it drops as the search enters the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (look_acc) begin
			busy_q <= 1'b1;
		end else if (link[DEPTH-1].valid) begin
			busy_q <= 1'b0;
		end
	end

	// search request enters the chain with an empty result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_v_q <= 1'b0;
			req_q   <= '0;
		end else begin
			ins_v_q     <= ins_acc;
			req_q.valid <= look_acc;
			if (look_acc) begin
				req_q.found  <= 1'b0;
				req_q.action <= act;
				req_q.x      <= pos_x;
				req_q.y      <= pos_y;
				req_q.code   <= code_id;
				req_q.frag   <= frag;
				req_q.lo     <= range_min;
				req_q.hi     <= range_max;
				req_q.slot   <= '0;
				req_q.rx     <= '0;
				req_q.ry     <= '0;
				req_q.rfrag  <= '0;
				req_q.rhops  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins_acc) begin
			ins_slot_q <= 4'(wp_next);
			ins_x_q    <= pos_x;
			ins_y_q    <= pos_y;
			ins_frag_q <= frag;
			ins_hops_q <= hops_in;
		end
	end

	assign link[0] = req_q;

	assign wr.x    = pos_x;
	assign wr.y    = pos_y;
	assign wr.code = code_id;
	assign wr.frag = frag;
	assign wr.hops = hops_in;

	// one cell per slot; a slot takes part only once filled
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign filled[i] = (FILL_W'(i) < fill_q);
		assign wr_en[i]  = ins_acc && (wp_next == PTR_W'(i));

		fmc_cell #(
			.IDX (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.filled (filled[i]),
			.wr_en  (wr_en[i]),
			.wr     (wr),
			.tok_i  (link[i]),
			.tok_o  (link[i+1])
		);
	end

	// a miss leaves the zeroed result fields from the chain entry
	always_comb begin
		if (ins_v_q) begin
			hit        = 1'b1;
			slot       = ins_slot_q;
			match_x    = ins_x_q;
			match_y    = ins_y_q;
			match_frag = ins_frag_q;
			match_hops = ins_hops_q;
		end else begin
			hit        = link[DEPTH].found;
			slot       = link[DEPTH].slot;
			match_x    = link[DEPTH].rx;
			match_y    = link[DEPTH].ry;
			match_frag = link[DEPTH].rfrag;
			match_hops = link[DEPTH].rhops;
		end
	end

	assign done = ins_v_q || link[DEPTH].valid;

	`FMC_ASSERT_NXT(a_lookup_busy, look_acc, busy)
	`FMC_ASSERT_NXT(a_insert_result, ins_acc, done && hit)
	`FMC_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FILL_W'(DEPTH))
	`FMC_ASSERT_IMP(a_single_result, link[DEPTH].valid, !busy_q && !ins_v_q)

endmodule

// File: verif/fifo_replace_match_cache_checker.sv
`timescale 1ns / 1ps

module fifo_replace_match_cache_checker
	import fmc_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [1:0] action,
	input  logic [7:0] pos_x,
	input  logic [7:0] pos_y,
	input  logic [7:0] code_id,
	input  logic [7:0] frag,
	input  logic [7:0] range_min,
	input  logic [7:0] range_max,
	input  logic [7:0] hops_in,
	input  logic       done,
	input  logic       hit,
	input  logic [3:0] slot,
	input  logic [7:0] match_x,
	input  logic [7:0] match_y,
	input  logic [7:0] match_frag,
	input  logic [7:0] match_hops,
	output int         mismatch_count,
	output int         results_owed
);

	typedef struct packed {
		logic       hit;
		logic [3:0] slot;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] frag;
		logic [7:0] hops;
	} cache_result_t;

	// shadow of the fragment table
	logic [7:0] ent_x    [DEPTH];
	logic [7:0] ent_y    [DEPTH];
	logic [7:0] ent_code [DEPTH];
	logic [7:0] ent_frag [DEPTH];
	logic [7:0] ent_hops [DEPTH];
	int         fill;
	int         wr_ptr;

	cache_result_t owed_q[$];
	cache_result_t oldest;

	function automatic cache_result_t compute_cache_result(input fmc_act_t act,
			input logic [7:0] x, input logic [7:0] y, input logic [7:0] code,
			input logic [7:0] fr, input logic [7:0] lo, input logic [7:0] hi,
			input logic [7:0] hops);
		cache_result_t res;
		bit            in_range;
		bit            key_eq;
		bit            match;
		res = '0;
		if (act == ACT_INSERT) begin
			if (fill < DEPTH)
				fill++;
			wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
			ent_x[wr_ptr]    = x;
			ent_y[wr_ptr]    = y;
			ent_code[wr_ptr] = code;
			ent_frag[wr_ptr] = fr;
			ent_hops[wr_ptr] = hops;
			res.hit  = 1'b1;
			res.slot = wr_ptr[3:0];
			res.x    = x;
			res.y    = y;
			res.frag = fr;
			res.hops = hops;
			return res;
		end
		// lowest filled slot wins
		for (int i = 0; i < fill; i++) begin
			in_range = ent_frag[i] >= lo && ent_frag[i] <= hi;
			key_eq   = ent_x[i] == x && ent_y[i] == y && ent_code[i] == code;
			case (act)
				ACT_FIND_EXACT:    match = key_eq && ent_frag[i] == fr;
				ACT_FIND_XY_RANGE: match = key_eq && in_range;
				default:           match = ent_code[i] == code && in_range;
			endcase
			if (match) begin
				res.hit  = 1'b1;
				res.slot = i[3:0];
				res.x    = ent_x[i];
				res.y    = ent_y[i];
				res.frag = ent_frag[i];
				res.hops = ent_hops[i];
				return res;
			end
		end
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill   = 0;
			wr_ptr = DEPTH - 1;
			for (int i = 0; i < DEPTH; i++)
				ent_hops[i] = HOPS_UNKNOWN;
			owed_q.delete();
			mismatch_count = 0;
			results_owed <= 0;
		end else begin
			// retire the oldest request before taking a new one
			if (done) begin
				if (owed_q.size() == 0) begin
					$error("result strobed with no request outstanding");
					mismatch_count++;
				end else begin
					oldest = owed_q.pop_front();
					check_field("hit", {7'd0, oldest.hit}, {7'd0, hit});
					check_field("slot", {4'd0, oldest.slot}, {4'd0, slot});
					check_field("match_x", oldest.x, match_x);
					check_field("match_y", oldest.y, match_y);
					check_field("match_frag", oldest.frag, match_frag);
					check_field("match_hops", oldest.hops, match_hops);
				end
			end
			if (start && !busy)
				owed_q.push_back(compute_cache_result(fmc_act_t'(action), pos_x, pos_y,
					code_id, frag, range_min, range_max, hops_in));
			results_owed <= owed_q.size();
		end
	end

endmodule

// File: verif/fifo_replace_match_cache_tb.sv
`timescale 1ns / 1ps

module fifo_replace_match_cache_tb;
	import fmc_pkg::*;

	localparam int CACHE_DEPTH     = 16;
	localparam int RANDOM_REQUESTS = 1650;
	// drain limit, far more than one lookup needs to walk the whole row
	localparam int DRAIN_LIMIT     = 4000;

	// what the stimulus remembers of recent inserts, to aim lookups at real entries
	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] code;
		logic [7:0] frag;
	} frag_rec_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       start     = 1'b0;
	logic [1:0] action    = ACT_INSERT;
	logic [7:0] pos_x     = '0;
	logic [7:0] pos_y     = '0;
	logic [7:0] code_id   = '0;
	logic [7:0] frag      = '0;
	logic [7:0] range_min = '0;
	logic [7:0] range_max = '0;
	logic [7:0] hops_in   = '0;

	logic       busy;
	logic       done;
	logic       hit;
	logic [3:0] slot;
	logic [7:0] match_x;
	logic [7:0] match_y;
	logic [7:0] match_frag;
	logic [7:0] match_hops;

	int         mismatch_count;
	int         results_owed;

	// when set, requests go back to back with no idle cycles
	bit         no_gaps = 1'b0;
	frag_rec_t  written_q[$];

	fifo_replace_match_cache #(
		.DEPTH(CACHE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.code_id(code_id),
		.frag(frag),
		.range_min(range_min),
		.range_max(range_max),
		.hops_in(hops_in),
		.done(done),
		.hit(hit),
		.slot(slot),
		.match_x(match_x),
		.match_y(match_y),
		.match_frag(match_frag),
		.match_hops(match_hops)
	);

	fifo_replace_match_cache_checker #(
		.DEPTH(CACHE_DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.code_id(code_id),
		.frag(frag),
		.range_min(range_min),
		.range_max(range_max),
		.hops_in(hops_in),
		.done(done),
		.hit(hit),
		.slot(slot),
		.match_x(match_x),
		.match_y(match_y),
		.match_frag(match_frag),
		.match_hops(match_hops),
		.mismatch_count(mismatch_count),
		.results_owed(results_owed)
	);

	// 12 ns clock
	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// keys come half the time from a tiny pool and collide often, which makes hits and multiple matches likely
	function automatic logic [7:0] pick_key();
		case ($urandom_range(0, 3))
			0:       return 8'($urandom_range(0, 3));
			1:       return 8'(255 - $urandom_range(0, 1));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one request: optional idle gap, then hold start until busy is seen low at an edge
	task automatic send_request(input fmc_act_t act, input logic [7:0] x,
			input logic [7:0] y, input logic [7:0] code, input logic [7:0] fr,
			input logic [7:0] lo, input logic [7:0] hi, input logic [7:0] hops);
		int        gap;
		frag_rec_t rec;
		gap = no_gaps ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		action    <= act;
		pos_x     <= x;
		pos_y     <= y;
		code_id   <= code;
		frag      <= fr;
		range_min <= lo;
		range_max <= hi;
		hops_in   <= hops;
		do @(posedge clk); while (busy);
		// the table only keeps the last DEPTH inserts
		if (act == ACT_INSERT) begin
			rec.x    = x;
			rec.y    = y;
			rec.code = code;
			rec.frag = fr;
			written_q.push_back(rec);
			if (written_q.size() > CACHE_DEPTH)
				void'(written_q.pop_front());
		end
	endtask

	initial begin
		fmc_act_t   act;
		frag_rec_t  pick;
		logic [7:0] rx;
		logic [7:0] ry;
		logic [7:0] rc;
		logic [7:0] rf;
		logic [7:0] rlo;
		logic [7:0] rhi;
		logic [7:0] rh;
		int         lo_i;
		int         hi_i;
		int         waited;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lookups on an empty table must all miss
		send_request(ACT_FIND_EXACT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00);
		send_request(ACT_FIND_XY_RANGE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00);
		send_request(ACT_FIND_CODE_RANGE, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff);

		// field extremes, hop count zero and unknown
		send_request(ACT_INSERT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(ACT_INSERT, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, HOPS_UNKNOWN);
		// same key twice with different fragments, for lowest-index picking
		send_request(ACT_INSERT, 8'h5a, 8'ha5, 8'h3c, 8'h10, 8'h00, 8'h00, 8'd7);
		send_request(ACT_INSERT, 8'h5a, 8'ha5, 8'h3c, 8'h20, 8'hff, 8'hff, 8'd9);

		// exact lookups: hits on both extremes, then a near miss on fragment
		send_request(ACT_FIND_EXACT, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00);
		send_request(ACT_FIND_EXACT, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff);
		send_request(ACT_FIND_EXACT, 8'h5a, 8'ha5, 8'h3c, 8'h11, 8'h00, 8'hff, 8'h00);

		// x/y/code in range: full range, narrow range, single value, empty range
		send_request(ACT_FIND_XY_RANGE, 8'h5a, 8'ha5, 8'h3c, 8'h00, 8'h00, 8'hff, 8'h00);
		send_request(ACT_FIND_XY_RANGE, 8'h5a, 8'ha5, 8'h3c, 8'h00, 8'h11, 8'h20, 8'h00);
		send_request(ACT_FIND_XY_RANGE, 8'h5a, 8'ha5, 8'h3c, 8'h00, 8'h20, 8'h20, 8'h00);
		send_request(ACT_FIND_XY_RANGE, 8'h5a, 8'ha5, 8'h3c, 8'h00, 8'h20, 8'h10, 8'h00);

		// code in range: hit, top single value, miss just above zero
		send_request(ACT_FIND_CODE_RANGE, 8'h00, 8'h00, 8'h3c, 8'h00, 8'h00, 8'hff, 8'h00);
		send_request(ACT_FIND_CODE_RANGE, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00);
		send_request(ACT_FIND_CODE_RANGE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hff, 8'h00);

		// random part: mostly lookups aimed at live entries, the rest pure noise;
		// enough inserts that the ring wraps many times
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 150 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 4)
				act = ACT_INSERT;
			else
				act = fmc_act_t'($urandom_range(1, 3));
			rx  = pick_key();
			ry  = pick_key();
			rc  = pick_key();
			rf  = pick_key();
			rlo = 8'($urandom_range(0, 255));
			rhi = 8'($urandom_range(0, 255));
			rh  = ($urandom_range(0, 7) == 0) ? HOPS_UNKNOWN : 8'($urandom_range(0, 255));
			if (act != ACT_INSERT && written_q.size() != 0 && $urandom_range(0, 9) < 7) begin
				pick = written_q[$urandom_range(0, written_q.size() - 1)];
				rx = pick.x;
				ry = pick.y;
				rc = pick.code;
				rf = pick.frag;
				// occasionally change at most one bit of the key
				if ($urandom_range(0, 7) == 0) begin
					case ($urandom_range(0, 3))
						0:       rx[$urandom_range(0, 7)] = ~rx[$urandom_range(0, 7)];
						1:       ry[$urandom_range(0, 7)] = ~ry[$urandom_range(0, 7)];
						2:       rc[$urandom_range(0, 7)] = ~rc[$urandom_range(0, 7)];
						default: rf[$urandom_range(0, 7)] = ~rf[$urandom_range(0, 7)];
					endcase
				end
				case ($urandom_range(0, 4))
					0: begin
						rlo = 8'h00;
						rhi = 8'hff;
					end
					1: begin
						rlo = pick.frag;
						rhi = pick.frag;
					end
					2: begin
						lo_i = int'(pick.frag) - int'($urandom_range(0, 24));
						hi_i = int'(pick.frag) + int'($urandom_range(0, 24));
						rlo  = (lo_i < 0) ? 8'h00 : 8'(lo_i);
						rhi  = (hi_i > 255) ? 8'hff : 8'(hi_i);
					end
					3: begin
						// empty range
						rlo = 8'($urandom_range(1, 255));
						rhi = 8'($urandom_range(0, int'(rlo) - 1));
					end
					default: ;
				endcase
			end
			send_request(act, rx, ry, rc, rf, rlo, rhi, rh);
		end
		start <= 1'b0;

		// drain, then let one more lookup time pass
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (results_owed != 0 && waited < DRAIN_LIMIT);
		if (results_owed != 0) begin
			$display("[FAIL] regression broken");
		end else begin
			repeat (CACHE_DEPTH + 4) @(posedge clk);
			if (mismatch_count == 0) begin
				$display("[ OK ] regression clean");
			end else begin
				$display("[FAIL] regression broken");
			end
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/fmc_pkg.sv
rtl/fmc_cell.sv
rtl/fifo_replace_match_cache.sv
verif/fifo_replace_match_cache_checker.sv
verif/fifo_replace_match_cache_tb.sv
